### design/exact_lru_frame_replacement_macros.svh
// Assertion macros for the exact LRU frame replacement block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef EXACT_LRU_FRAME_REPLACEMENT_MACROS_SVH
`define EXACT_LRU_FRAME_REPLACEMENT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ELRU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
// next-cycle implication
`define ELRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define ELRU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ELRU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/elru_pkg.sv
// Package for the exact LRU frame replacement block: sizes, action codes,
// cell control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package elru_pkg;
   localparam int FRAMES  = 64;
   localparam int FRAME_W = 6;
   // frames beyond the field range can never be referenced
   localparam int SLOTS   = (FRAMES < (2 ** FRAME_W)) ? FRAMES : (2 ** FRAME_W);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int LEVELS  = $clog2(SLOTS);
   localparam int PRES_N  = 2 ** FRAME_W;

   localparam logic ACT_REFERENCE = 1'b0;
   localparam logic ACT_EVICT     = 1'b1;

   typedef logic [FRAME_W-1:0] frame_type;

   typedef struct packed {
      logic shift;     // load frame from the more-recent neighbor
      logic occupied;  // slot is below the tracked count
   } cell_ctl_type;
endpackage
`default_nettype wire

### design/elru_if.sv
// Channel interfaces (valid/ready plus payload) for request and response words.
// Depends on elru_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface elru_req_if;
   import elru_pkg::*;
   logic      valid;
   logic      ready;
   logic      action;
   frame_type frame;
   modport source (output valid, output action, output frame, input ready);
   modport sink   (input valid, input action, input frame, output ready);
endinterface

interface elru_rsp_if;
   import elru_pkg::*;
   logic      valid;
   logic      ready;
   frame_type victim_frame;
   logic      victim_valid;
   logic      was_hit;
   modport source (output valid, output victim_frame, output victim_valid,
                   output was_hit, input ready);
   modport sink   (input valid, input victim_frame, input victim_valid,
                   input was_hit, output ready);
endinterface
`default_nettype wire

### design/elru_cell.sv
// One recency slot: holds a frame number, shifts from its neighbor, compares.
// Depends on elru_pkg.
`timescale 1ns / 1ps
`default_nettype none
module elru_cell (
   input  wire logic                  clock,
   input  wire elru_pkg::cell_ctl_type ctl,
   input  wire elru_pkg::frame_type   left_frame,
   input  wire elru_pkg::frame_type   ref_frame,
   output elru_pkg::frame_type        frame_out,
   output logic                       match
);
   import elru_pkg::*;

   frame_type frame_ff;
   frame_type frame_in;

   always_comb begin
      frame_in = ctl.shift ? left_frame : frame_ff;
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign frame_out = frame_ff;
   assign match     = ctl.occupied && (frame_ff == ref_frame);
endmodule
`default_nettype wire

### design/elru_scan.sv
// Parallel suffix-OR over the cell match flags: bit i is set when any cell
// at index i or above matches. Depends on elru_pkg.
`timescale 1ns / 1ps
`default_nettype none
module elru_scan (
   input  wire logic [elru_pkg::SLOTS-1:0] match_vec,
   output logic      [elru_pkg::SLOTS-1:0] suffix_vec
);
   import elru_pkg::*;

   logic [SLOTS-1:0] lvl [0:LEVELS];

   assign lvl[0] = match_vec;

   for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
      for (genvar i = 0; i < SLOTS; i++) begin : g_bit
         if (i + (2 ** l) < SLOTS) begin : g_or
            assign lvl[l+1][i] = lvl[l][i] | lvl[l][i + (2 ** l)];
         end else begin : g_pass
            assign lvl[l+1][i] = lvl[l][i];
         end
      end
   end

   assign suffix_vec = lvl[LEVELS];
endmodule
`default_nettype wire

### design/exact_lru_frame_replacement.sv
// Exact LRU frame replacement top level: chain of recency cells, presence
// bitmap, response register. Depends on elru_pkg, elru_if, elru_cell, elru_scan and the assertion macros.
//
//   channel   dir   handshake       payload
//   req_bus   in    valid / ready   action, frame
//   rsp_bus   out   valid / ready   victim_frame, victim_valid, was_hit
//
// One word per cycle unless the response stalls: the cell row updates in the
// accepting cycle and the response is in the output register the cycle after.
// Throughput is set by the output register: a new word is taken whenever the
// register is empty or being drained in the same cycle.
// Reset clears the tracked count, the presence bitmap and the response valid;
// slot contents are not reset and are only read below the tracked count.
`timescale 1ns / 1ps
`default_nettype none
`include "exact_lru_frame_replacement_macros.svh"
module exact_lru_frame_replacement (
   input wire logic  clock,
   input wire logic  reset,
   elru_req_if.sink   req_bus,
   elru_rsp_if.source rsp_bus
);
   import elru_pkg::*;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PRES_N-1:0] present_ff, present_in;
   logic              rsp_valid_ff, rsp_valid_in;
   frame_type         rsp_victim_ff, rsp_victim_in;
   logic              rsp_vvalid_ff, rsp_vvalid_in;
   logic              rsp_hit_ff, rsp_hit_in;

   logic              fire, is_evict, in_range, hit, do_ref, do_evict;
   frame_type         victim;
   logic [SLOTS-1:0]  match_vec, suffix_vec;
   frame_type         cell_frame [0:SLOTS-1];
   cell_ctl_type      cell_ctl   [0:SLOTS-1];

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = req_bus.valid && req_bus.ready;
   assign is_evict      = (req_bus.action == ACT_EVICT);
   assign in_range      = ({{(32-FRAME_W){1'b0}}, req_bus.frame} < 32'(FRAMES));
   assign hit           = in_range && present_ff[req_bus.frame];
   assign do_ref        = fire && !is_evict && in_range;
   assign do_evict      = fire && is_evict && (cnt_ff != '0);

   // slot 0 is most recent; the least recent sits at cnt_ff-1
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      always_comb begin
         cell_ctl[i].occupied = (CNT_W'(i) < cnt_ff);
         cell_ctl[i].shift    = do_ref && (!hit || suffix_vec[i]);
      end

      if (i == 0) begin : g_head
         elru_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[i]),
            .left_frame (req_bus.frame),
            .ref_frame  (req_bus.frame),
            .frame_out  (cell_frame[i]),
            .match      (match_vec[i])
         );
      end else begin : g_body
         elru_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[i]),
            .left_frame (cell_frame[i-1]),
            .ref_frame  (req_bus.frame),
            .frame_out  (cell_frame[i]),
            .match      (match_vec[i])
         );
      end
   end

   elru_scan u_scan (
      .match_vec  (match_vec),
      .suffix_vec (suffix_vec)
   );

   always_comb begin
      victim = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (cnt_ff == CNT_W'(i + 1)) begin
            victim = victim | cell_frame[i];
         end
      end
   end

   always_comb begin
      cnt_in     = cnt_ff;
      present_in = present_ff;
      if (do_evict) begin
         cnt_in             = cnt_ff - CNT_W'(1);
         present_in[victim] = 1'b0;
      end else if (do_ref) begin
         if (!hit) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         present_in[req_bus.frame] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_victim_in = rsp_victim_ff;
      rsp_vvalid_in = rsp_vvalid_ff;
      rsp_hit_in    = rsp_hit_ff;
      if (fire) begin
         rsp_valid_in  = 1'b1;
         rsp_victim_in = do_evict ? victim : '0;
         rsp_vvalid_in = do_evict;
         rsp_hit_in    = !is_evict && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_victim_ff <= rsp_victim_in;
      rsp_vvalid_ff <= rsp_vvalid_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.victim_frame = rsp_victim_ff;
   assign rsp_bus.victim_valid = rsp_vvalid_ff;
   assign rsp_bus.was_hit      = rsp_hit_ff;

   `ELRU_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(SLOTS))
   `ELRU_ASSERT_IMPL(a_cnt_bitmap, clock, reset, 1'b1, $countones(present_ff) == int'(cnt_ff))
   `ELRU_ASSERT_IMPL(a_hit_agree, clock, reset, do_ref, hit == (|match_vec))
   `ELRU_ASSERT_NEXT(a_evict_dec, clock, reset, do_evict, cnt_ff == $past(cnt_ff) - CNT_W'(1))
endmodule
`default_nettype wire
